>>> rtl/deadline_timer_set_assert.svh
`ifndef DEADLINE_TIMER_SET_ASSERT_SVH
`define DEADLINE_TIMER_SET_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DTS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dts_pkg.sv
package dts_pkg;

  localparam int DEF_NUM_TIMERS = 16;
  localparam logic [31:0] ONE_DAY_MS = 32'd86400000;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_EXPIRE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_FIND_WAKE,
    ST_FIND_OUT,
    ST_EXP_CHECK,
    ST_EXP_TEST,
    ST_EXP_DONE
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  timer_id;
    logic [31:0] timeout_ms;
    logic [15:0] slack_ms;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  fired_id;
    logic [31:0] wait_ms;
    logic        last;
  } out_t;

  typedef struct packed {
    logic dl_we;
    logic sl_we;
  } store_wr_t;

endpackage

>>> rtl/deadline_timer_set.sv
// Add: ADD_RD reads the old entry, ADD_WR writes it and acks; an out-of-range id
// and a remove ack from idle. Find: a table scan at one entry per cycle, then
// FIND_WAKE and FIND_OUT. Expire: EXP_CHECK, then EXP_DONE while the earliest
// wake is still ahead, else a scan and EXP_TEST, once more per fired timer. A new
// transaction is accepted only while idle, at the edge that ends the final result.
// Reset clears armed bits, current time and earliest wake; no stalls.
module deadline_timer_set #(
  parameter int NUM_TIMERS = dts_pkg::DEF_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dts_pkg::in_t  in_item,
  output logic          busy,
  output logic          out_valid,
  output dts_pkg::out_t out_item
);
  import dts_pkg::*;

  localparam int AW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  state_t            state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [AW-1:0]     best_r, best_nxt;
  logic [31:0]       best_dl_r, best_dl_nxt;
  logic [15:0]       best_sl_r, best_sl_nxt;
  logic [31:0]       d_r, d_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic [31:0]       wake_r, wake_nxt;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  store_wr_t         wr;
  logic [AW-1:0]     addr;
  logic [31:0]       rd_dl;
  logic [15:0]       rd_sl;

  logic [31:0]       alu_a, alu_b, alu_y;
  logic              alu_sub;

  logic              in_id_ok, id_ok;
  logic [AW-1:0]     in_addr, id_addr;
  logic [31:0]       mag;
  logic              keep;

  dts_store #(.NUM_TIMERS(NUM_TIMERS)) u_store (
    .clk   (clk),
    .wr    (wr),
    .addr  (addr),
    .wr_dl (d_r),
    .wr_sl (cmd_r.slack_ms),
    .rd_dl (rd_dl),
    .rd_sl (rd_sl)
  );

  // The shared adder of the state machine: a + b, or a - b for wrap-around differences.
  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + 32'(alu_sub);

  assign in_id_ok = int'(in_item.timer_id) < NUM_TIMERS;
  assign id_ok    = int'(cmd_r.timer_id) < NUM_TIMERS;
  assign in_addr  = AW'(in_item.timer_id);
  assign id_addr  = AW'(cmd_r.timer_id);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= '0;
      cur_r       <= '0;
      wake_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      best_vld_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      cur_r       <= cur_nxt;
      wake_r      <= wake_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      best_vld_r  <= best_vld_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    best_sl_r  <= best_sl_nxt;
    d_r        <= d_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    best_vld_nxt  = best_vld_r;
    best_nxt      = best_r;
    best_dl_nxt   = best_dl_r;
    best_sl_nxt   = best_sl_r;
    d_nxt         = d_r;
    cur_nxt       = cur_r;
    wake_nxt      = wake_r;
    armed_nxt     = armed_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    wr            = '0;
    addr          = idx_r[AW-1:0];
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    mag           = '0;
    keep          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
          case (in_item.mode)
            MODE_ADD: begin
              if (in_id_ok) begin
                state_nxt = ST_ADD_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{KIND_ACK, 4'd0, 32'd0, 1'b1};
              end
            end
            MODE_REMOVE: begin
              if (in_id_ok) begin
                armed_nxt[in_addr] = 1'b0;
              end
              out_valid_nxt = 1'b1;
              out_nxt       = '{KIND_ACK, 4'd0, 32'd0, 1'b1};
            end
            MODE_FIND: begin
              idx_nxt      = '0;
              pend_nxt     = 1'b0;
              best_vld_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
            MODE_EXPIRE: begin
              cur_nxt   = in_item.now_ms;
              state_nxt = ST_EXP_CHECK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ADD_RD: begin
        addr      = id_addr;
        alu_a     = cur_r;
        alu_b     = cmd_r.timeout_ms;
        d_nxt     = alu_y;
        state_nxt = ST_ADD_WR;
      end

      ST_ADD_WR: begin
        addr    = id_addr;
        alu_a   = d_r;
        alu_b   = rd_dl;
        alu_sub = 1'b1;
        // The most negative difference has magnitude 2^31 and is never kept.
        mag     = alu_y[31] ? (~alu_y + 32'd1) : alu_y;
        keep    = id_ok && armed_r[id_addr] && (mag <= 32'(cmd_r.slack_ms));
        wr.sl_we = 1'b1;
        wr.dl_we = !keep;
        armed_nxt[id_addr] = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = '{KIND_ACK, 4'd0, 32'd0, 1'b1};
        state_nxt     = ST_IDLE;
      end

      ST_SCAN: begin
        // Read data is registered in the store, so compare the entry
        // issued last cycle while the next one is being read.
        if (pend_r && armed_r[pend_idx_r]) begin
          alu_a   = rd_dl;
          alu_b   = best_dl_r;
          alu_sub = 1'b1;
          if (!best_vld_r || alu_y[31]) begin
            best_vld_nxt = 1'b1;
            best_nxt     = pend_idx_r;
            best_dl_nxt  = rd_dl;
            best_sl_nxt  = rd_sl;
          end
        end
        if (idx_r < CW'(NUM_TIMERS)) begin
          addr         = idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = (cmd_r.mode == MODE_FIND) ? ST_FIND_WAKE : ST_EXP_TEST;
        end
      end

      ST_FIND_WAKE: begin
        if (best_vld_r) begin
          alu_a   = best_dl_r;
          alu_b   = 32'(best_sl_r);
          alu_sub = 1'b1;
        end else begin
          alu_a = cur_r;
          alu_b = ONE_DAY_MS;
        end
        wake_nxt  = alu_y;
        state_nxt = ST_FIND_OUT;
      end

      ST_FIND_OUT: begin
        alu_a         = best_dl_r;
        alu_b         = cur_r;
        alu_sub       = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt.kind     = KIND_WAIT;
        out_nxt.fired_id = 4'd0;
        out_nxt.last     = 1'b1;
        if (!best_vld_r) begin
          out_nxt.wait_ms = '1;
        end else if (alu_y[31]) begin
          out_nxt.wait_ms = '0;
        end else begin
          out_nxt.wait_ms = alu_y;
        end
        state_nxt = ST_IDLE;
      end

      ST_EXP_CHECK: begin
        alu_a   = wake_r;
        alu_b   = cur_r;
        alu_sub = 1'b1;
        if (alu_y[31] || (alu_y == 32'd0)) begin
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          best_vld_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt = ST_EXP_DONE;
        end
      end

      ST_EXP_TEST: begin
        alu_a   = best_dl_r;
        alu_b   = cur_r;
        alu_sub = 1'b1;
        if (!best_vld_r || (!alu_y[31] && (alu_y > 32'(best_sl_r)))) begin
          state_nxt = ST_EXP_DONE;
        end else begin
          armed_nxt[best_r] = 1'b0;
          out_valid_nxt     = 1'b1;
          out_nxt           = '{KIND_FIRED, 4'(best_r), 32'd0, 1'b0};
          idx_nxt           = '0;
          pend_nxt          = 1'b0;
          best_vld_nxt      = 1'b0;
          state_nxt         = ST_SCAN;
        end
      end

      ST_EXP_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{KIND_DONE, 4'd0, 32'd0, 1'b1};
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/dts_store.sv
module dts_store #(
  parameter int NUM_TIMERS = dts_pkg::DEF_NUM_TIMERS
) (
  input  logic                            clk,
  input  dts_pkg::store_wr_t              wr,
  input  logic [$clog2(NUM_TIMERS)-1:0]   addr,
  input  logic [31:0]                     wr_dl,
  input  logic [15:0]                     wr_sl,
  output logic [31:0]                     rd_dl,
  output logic [15:0]                     rd_sl
);
  import dts_pkg::*;

  logic [31:0] dl_mem [NUM_TIMERS];
  logic [15:0] sl_mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.dl_we) begin
      dl_mem[addr] <= wr_dl;
    end
    if (wr.sl_we) begin
      sl_mem[addr] <= wr_sl;
    end
    rd_dl <= dl_mem[addr];
    rd_sl <= sl_mem[addr];
  end

endmodule

>>> rtl/deadline_timer_set_chk.sv
`include "deadline_timer_set_assert.svh"

module deadline_timer_set_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input dts_pkg::in_t  in_item,
  input logic          busy,
  input logic          out_valid,
  input dts_pkg::out_t out_item
);
  import dts_pkg::*;

  // Only a fired timer leaves the expire transaction open.
  `DTS_ASSERT_SAME(a_last_on_final, out_valid && (out_item.kind != KIND_FIRED), out_item.last, "non-fire result without last")
  `DTS_ASSERT_SAME(a_fire_mid_seq, out_valid && (out_item.kind == KIND_FIRED), !out_item.last && busy, "fire result must be mid-sequence")
  `DTS_ASSERT_SAME(a_idle_is_final, out_valid && !busy, out_item.last, "result while idle is not final")
  `DTS_ASSERT_NEXT(a_scan_goes_busy, start && !busy && ((in_item.mode == MODE_FIND) || (in_item.mode == MODE_EXPIRE)), busy, "find or expire did not start a scan")

endmodule

bind deadline_timer_set deadline_timer_set_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_item   (in_item),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> tb/sv/tb_deadline_timer_set.sv
`timescale 1ns / 1ps

module tb_deadline_timer_set;
  import dts_pkg::*;

  localparam int NT = DEF_NUM_TIMERS;
  localparam int RANDOM_ITEMS = 206;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP = 50;

  logic clk;
  logic rst_n;
  logic start;
  in_t in_item;
  logic busy;
  logic out_valid;
  out_t out_item;

  deadline_timer_set #(
    .NUM_TIMERS(NT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  class timer_set_scoreboard;
    bit armed_tbl[NT];
    logic [31:0] deadline_tbl[NT];
    logic [15:0] slack_tbl[NT];
    logic [31:0] cur_time = '0;
    logic [31:0] wake_time = '0;
    out_t pending_results[$];
    int errors = 0;
    int n_fired = 0;
    int n_waits = 0;
    int n_cmds = 0;
    int mode_count[4] = '{0, 0, 0, 0};

    function logic signed [31:0] wdiff(logic [31:0] a, logic [31:0] b);
      return a - b;
    endfunction

    // Scan in id order; a later entry replaces the best only when strictly earlier.
    function int earliest_armed();
      int best;
      best = -1;
      for (int i = 0; i < NT; i++)
        if (armed_tbl[i] && (best < 0 || wdiff(deadline_tbl[i], deadline_tbl[best]) < 0))
          best = i;
      return best;
    endfunction

    function void report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void note_command(in_t c);
      int e;
      logic [31:0] d;
      logic [31:0] mag;
      logic signed [31:0] df;
      bit keep;
      out_t r;
      out_t f;
      r = '0;
      r.last = 1'b1;
      n_cmds++;
      mode_count[c.mode]++;
      case (c.mode)
        MODE_ADD: begin
          d = cur_time + c.timeout_ms;
          slack_tbl[c.timer_id] = c.slack_ms;
          keep = 1'b0;
          if (armed_tbl[c.timer_id]) begin
            df = wdiff(d, deadline_tbl[c.timer_id]);
            mag = df[31] ? (32'd0 - df) : df;
            keep = (mag <= {16'd0, c.slack_ms});
          end
          if (!keep) begin
            deadline_tbl[c.timer_id] = d;
            armed_tbl[c.timer_id] = 1'b1;
          end
          r.kind = KIND_ACK;
        end
        MODE_REMOVE: begin
          armed_tbl[c.timer_id] = 1'b0;
          r.kind = KIND_ACK;
        end
        MODE_FIND: begin
          e = earliest_armed();
          if (e >= 0) begin
            wake_time = deadline_tbl[e] - {16'd0, slack_tbl[e]};
            df = wdiff(deadline_tbl[e], cur_time);
            r.wait_ms = (df > 0) ? df : 32'd0;
          end else begin
            wake_time = cur_time + ONE_DAY_MS;
            r.wait_ms = '1;
          end
          r.kind = KIND_WAIT;
          n_waits++;
        end
        default: begin
          cur_time = c.now_ms;
          if (wdiff(wake_time, c.now_ms) <= 0) begin
            e = earliest_armed();
            while (e >= 0 &&
                   wdiff(deadline_tbl[e], c.now_ms) <= $signed({16'd0, slack_tbl[e]})) begin
              armed_tbl[e] = 1'b0;
              f = '0;
              f.kind = KIND_FIRED;
              f.fired_id = e[3:0];
              pending_results.push_back(f);
              n_fired++;
              e = earliest_armed();
            end
          end
          r.kind = KIND_DONE;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d id %0d wait %0h last %0d",
                         got.kind, got.fired_id, got.wait_ms, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.fired_id !== want.fired_id)
        report($sformatf("fired_id %0d, expected %0d", got.fired_id, want.fired_id));
      if (got.wait_ms !== want.wait_ms)
        report($sformatf("wait_ms %0h, expected %0h", got.wait_ms, want.wait_ms));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endfunction
  endclass

  timer_set_scoreboard sb;
  int burst_left = 0;
  int random_sent = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_result(out_item);
      else if (out_valid !== 1'b0) sb.report("out_valid is unknown");
    end
  end

  function automatic in_t mk(mode_t m, logic [3:0] id, logic [31:0] tmo,
                             logic [15:0] sl, logic [31:0] now);
    in_t c;
    c.mode = m;
    c.timer_id = id;
    c.timeout_ms = tmo;
    c.slack_ms = sl;
    c.now_ms = now;
    return c;
  endfunction

  function automatic in_t rand_fields();
    return mk(mode_t'($urandom_range(0, 3)), 4'($urandom), $urandom, 16'($urandom), $urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send(input in_t c);
    in_item <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic paced_send(input in_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = 40;
      end else begin
        idle($urandom_range(1, 24));
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    send(c);
  endtask

  function automatic in_t table_update();
    in_t c;
    c = rand_fields();
    if ($urandom_range(0, 99) < 30) begin
      c.mode = MODE_REMOVE;
    end else begin
      c.mode = MODE_ADD;
      if (sb.armed_tbl[c.timer_id] && $urandom_range(0, 2) == 0) begin
        // Re-add close to the current deadline so the slack decides.
        c.timeout_ms = sb.deadline_tbl[c.timer_id] - sb.cur_time + $urandom_range(0, 60) - 30;
        c.slack_ms = $urandom_range(0, 50);
      end else begin
        if ($urandom_range(0, 9) < 8) c.timeout_ms = $urandom_range(0, 3000);
        if ($urandom_range(0, 9) < 7) c.slack_ms = $urandom_range(0, 200);
      end
    end
    return c;
  endfunction

  function automatic in_t expire_cmd();
    in_t c;
    int r;
    c = rand_fields();
    c.mode = MODE_EXPIRE;
    r = $urandom_range(0, 99);
    if (r < 85) c.now_ms = sb.cur_time + $urandom_range(0, 2500);
    else if (r < 95) c.now_ms = sb.cur_time - $urandom_range(0, 500);
    return c;
  endfunction

  task automatic random_round();
    int n_ops;
    in_t c;
    n_ops = $urandom_range(1, 6);
    if ($urandom_range(0, 99) < 15) begin
      repeat (n_ops) paced_send(rand_fields());
      random_sent += n_ops;
    end else begin
      repeat (n_ops) paced_send(table_update());
      c = rand_fields();
      c.mode = MODE_FIND;
      paced_send(c);
      random_sent += n_ops + 1;
      if ($urandom_range(0, 9) < 8) begin
        paced_send(expire_cmd());
        random_sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, then an expire while the wake time is still a day ahead.
    paced_send(mk(MODE_FIND, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_EXPIRE, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_REMOVE, 4'd9, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_ADD, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_ADD, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // Equal deadlines on two ids, then re-adds inside and at the edge of the slack.
    paced_send(mk(MODE_ADD, 4'd7, 32'd500, 16'd20, 32'd0));
    paced_send(mk(MODE_ADD, 4'd8, 32'd500, 16'd0, 32'd0));
    paced_send(mk(MODE_ADD, 4'd7, 32'd515, 16'd20, 32'd0));
    paced_send(mk(MODE_ADD, 4'd7, 32'd480, 16'd20, 32'd0));
    paced_send(mk(MODE_ADD, 4'd8, 32'd500, 16'd0, 32'd0));
    // A re-add exactly half the number range away is never within the slack.
    paced_send(mk(MODE_ADD, 4'd5, 32'h10, 16'hFFFF, 32'd0));
    paced_send(mk(MODE_ADD, 4'd5, 32'h8000_0010, 16'hFFFF, 32'd0));
    paced_send(mk(MODE_FIND, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_EXPIRE, 4'd0, 32'd0, 16'd0, 32'd600));
    paced_send(mk(MODE_FIND, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_ADD, 4'd3, 32'hFFFF_FFFF, 16'd0, 32'd0));
    paced_send(mk(MODE_ADD, 4'd12, 32'h7FFF_FFFF, 16'hFFFF, 32'd0));
    paced_send(mk(MODE_EXPIRE, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFF));
    paced_send(mk(MODE_FIND, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_EXPIRE, 4'd0, 32'd0, 16'd0, 32'h8000_0000));
    paced_send(mk(MODE_REMOVE, 4'd12, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_REMOVE, 4'd5, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_FIND, 4'd0, 32'd0, 16'd0, 32'd0));
    paced_send(mk(MODE_EXPIRE, 4'd0, 32'd0, 16'd0, 32'h8000_0001));

    while (random_sent < RANDOM_ITEMS) random_round();
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (NT + 8) @(posedge clk);

    $display("Ran %0d transactions: %0d add, %0d remove, %0d find, %0d expire, in %0d cycles.",
             sb.n_cmds, sb.mode_count[MODE_ADD], sb.mode_count[MODE_REMOVE],
             sb.mode_count[MODE_FIND], sb.mode_count[MODE_EXPIRE], cycle_count);
    $display("Checked %0d fired timers and %0d wait answers; %0d mismatches.",
             sb.n_fired, sb.n_waits, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
